// ===== hdl/ste_pkg.sv =====
// Shared types and codes for the sorted unique edge table.
// Holds the item and result structs, the action codes and the cell control struct.
// No dependencies.
package ste_pkg;

    localparam int EDGE_W  = 16;
    localparam int POS_W   = 7;
    localparam int COUNT_W = 8;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [EDGE_W-1:0] edge_value;
    } t_item;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
        logic               overflow;
    } t_result;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic eval;      // capture compare flags against the held item
        logic shift_en;  // commit an insert: write or take the neighbor's entry
    } t_cell_ctl;

endpackage

// ===== hdl/ste_cell.sv =====
// One cell of the edge chain: holds one entry and its compare flags.
// Depends on ste_pkg.
module ste_cell #(
    parameter int INDEX   = 0,
    parameter int COUNT_W = 8
) (
    input  logic                             i_clk,
    input  ste_pkg::t_cell_ctl               i_ctl,
    input  logic signed [ste_pkg::EDGE_W-1:0] i_value,
    input  logic [COUNT_W-1:0]               i_count,
    input  logic                             i_prev_lt,
    input  logic signed [ste_pkg::EDGE_W-1:0] i_prev_entry,
    output logic                             o_lt,
    output logic                             o_match,
    output logic                             o_ins,
    output logic signed [ste_pkg::EDGE_W-1:0] o_entry
);
    import ste_pkg::*;

    logic signed [EDGE_W-1:0] r_entry;
    logic                     r_lt;
    logic                     r_match;
    logic                     w_valid;

    assign w_valid = (COUNT_W'(INDEX) < i_count);

    always_ff @(posedge i_clk) begin
        if (i_ctl.eval) begin
            r_lt    <= w_valid && (r_entry < i_value);
            r_match <= w_valid && (r_entry == i_value);
        end
        if (i_ctl.shift_en) begin
            if (o_ins) begin
                r_entry <= i_value;
            end else if (!i_prev_lt) begin
                r_entry <= i_prev_entry;
            end
        end
    end

    // This cell is the sorted place of the value: all below are smaller, it is not.
    assign o_ins   = i_prev_lt && !r_lt;
    assign o_lt    = r_lt;
    assign o_match = r_match;
    assign o_entry = r_entry;

endmodule

// ===== hdl/sorted_unique_edge_table.sv =====
// Top level of the sorted unique edge table: control, cell chain and result register.
// Depends on ste_pkg and ste_cell.
//
// Keeps up to TABLE_DEPTH signed 16-bit edge positions in ascending order with no
// duplicates, one entry per cell of a chain. Each item goes through the transfer in,
// an execute state in which every cell compares its entry with the value and
// registers its flags, and a commit state in which the sorted place is encoded,
// an insert shifts every larger entry one cell up, and the result is loaded into the
// output register. A new item is taken the cycle after commit, not while one is in
// progress; the commit waits only while the output register still holds an untaken
// result. The width of the one-hot to index encode over the chain sets the commit
// cycle's path. Cells beyond the fill count are never read. position is truncated to
// 7 bits when TABLE_DEPTH exceeds 128, and entry_count to 8 bits when it exceeds 255.
module sorted_unique_edge_table #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  ste_pkg::t_item   i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output ste_pkg::t_result o_result
);
    import ste_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EXEC   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    t_state r_state, n_state;

    t_item            r_item;
    logic [CNT_W-1:0] r_count, n_count;
    t_result          r_result, n_result;
    logic             r_out_valid;

    t_cell_ctl w_ctl;

    // chain wiring: index 0 is fed by a virtual "smaller" neighbor
    logic [TABLE_DEPTH:0]     w_lt;
    logic [TABLE_DEPTH-1:0]   w_match;
    logic [TABLE_DEPTH-1:0]   w_ins;
    logic signed [EDGE_W-1:0] w_entry [TABLE_DEPTH+1];

    logic             w_in_fire;
    logic             w_commit;
    logic             w_found;
    logic             w_full;
    logic             w_do_ins;
    logic [IDX_W-1:0] w_pos;

    assign o_ready   = (r_state == S_IDLE);
    assign w_in_fire = i_valid && o_ready;
    // commit once the output register is empty or being drained this cycle
    assign w_commit  = (r_state == S_COMMIT) && (!r_out_valid || i_ready);

    assign w_lt[0]    = 1'b1;
    assign w_entry[0] = r_item.edge_value;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            ste_cell #(
                .INDEX   (g),
                .COUNT_W (CNT_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_value      (r_item.edge_value),
                .i_count      (r_count),
                .i_prev_lt    (w_lt[g]),
                .i_prev_entry (w_entry[g]),
                .o_lt         (w_lt[g+1]),
                .o_match      (w_match[g]),
                .o_ins        (w_ins[g]),
                .o_entry      (w_entry[g+1])
            );
        end
    endgenerate

    // The sorted place is one-hot (or empty when full and larger than all).
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_ins[i]) begin
                w_pos = w_pos | IDX_W'(i);
            end
        end
    end

    assign w_found  = |w_match;
    assign w_full   = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_do_ins = (r_item.action == ACT_INSERT) && !w_found && !w_full;

    assign w_ctl.eval     = (r_state == S_EXEC);
    assign w_ctl.shift_en = w_commit && w_do_ins;

    // Next count and result, taken only on commit.
    always_comb begin
        n_count  = r_count;
        n_result = '0;
        unique case (r_item.action)
            ACT_INSERT: begin
                if (w_found) begin
                    n_result.found    = 1'b1;
                    n_result.position = POS_W'(w_pos);
                end else if (w_full) begin
                    n_result.overflow = 1'b1;
                end else begin
                    n_count           = r_count + CNT_W'(1);
                    n_result.position = POS_W'(w_pos);
                end
            end
            ACT_LOOKUP: begin
                if (w_found) begin
                    n_result.found    = 1'b1;
                    n_result.position = POS_W'(w_pos);
                end
            end
            ACT_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // unused code: leave the table alone
            end
        endcase
        n_result.entry_count = COUNT_W'(n_count);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_fire) n_state = S_EXEC;
            S_EXEC:   n_state = S_COMMIT;
            S_COMMIT: if (w_commit) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                // drop the result once its transfer completes
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold the item through compare and commit, hold the result.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_item <= i_item;
        end
        if (w_commit) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

// ===== bench/sorted_unique_edge_table_test.sv =====
// Self-checking bench for the sorted unique edge table: directed and random inserts,
// lookups and clears, each result checked against an in-bench sorted table predictor.
// Depends on ste_pkg and sorted_unique_edge_table.
module sorted_unique_edge_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ste_pkg::*;

    localparam int DEPTH        = 128;
    localparam int ITEM_TARGET  = 620;   // with unused-code items, about 650 transfers in all
    localparam int QUIET_AFTER  = 540;   // no idling on either side from here on
    localparam int LONG_HOLD    = 90;    // receiver hold-off long enough to back up the input
    localparam int SETTLE       = 10;
    localparam int PRINT_CAP    = 40;

    // Predicts every result from the accepted items and checks the returned ones in order.
    class edge_table_board;
        logic signed [EDGE_W-1:0] entries[$];   // ascending, no duplicates
        t_result                  pending[$];   // expected results, oldest first
        int errors;
        int n_items;
        int n_checked;
        int n_hits;
        int n_overflow;
        int peak_fill;

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Index of the equal entry (hit set), else of the first larger entry.
        function int find_slot(input logic signed [EDGE_W-1:0] v, output bit hit);
            hit = 1'b0;
            foreach (entries[i]) begin
                if (entries[i] == v) begin
                    hit = 1'b1;
                    return i;
                end
                if (entries[i] > v)
                    return i;
            end
            return entries.size();
        endfunction

        function void note_item(t_item it);
            t_result r;
            int      idx;
            bit      hit;
            r   = '0;
            idx = find_slot(it.edge_value, hit);
            case (it.action)
                ACT_INSERT: begin
                    if (hit) begin
                        r.found    = 1'b1;
                        r.position = POS_W'(idx);
                    end else if (entries.size() >= DEPTH) begin
                        r.overflow = 1'b1;
                    end else begin
                        entries.insert(idx, it.edge_value);
                        r.position = POS_W'(idx);
                    end
                end
                ACT_LOOKUP: begin
                    if (hit) begin
                        r.found    = 1'b1;
                        r.position = POS_W'(idx);
                    end
                end
                ACT_CLEAR: entries.delete();
                default: ;
            endcase
            r.entry_count = COUNT_W'(entries.size());
            pending.push_back(r);
            n_items++;
            if (r.found)
                n_hits++;
            if (r.overflow)
                n_overflow++;
            if (entries.size() > peak_fill)
                peak_fill = entries.size();
        endfunction

        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report($sformatf("result %h arrived with nothing expected", got));
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.found !== want.found)
                report($sformatf("result %0d: found %b, expected %b",
                                 n_checked, got.found, want.found));
            if (got.position !== want.position)
                report($sformatf("result %0d: position %0d, expected %0d",
                                 n_checked, got.position, want.position));
            if (got.entry_count !== want.entry_count)
                report($sformatf("result %0d: entry_count %0d, expected %0d",
                                 n_checked, got.entry_count, want.entry_count));
            if (got.overflow !== want.overflow)
                report($sformatf("result %0d: overflow %b, expected %b",
                                 n_checked, got.overflow, want.overflow));
        endtask
    endclass

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    t_item   i_item  = '0;
    logic    i_ready = 1'b0;
    logic    o_ready;
    logic    o_valid;
    t_result o_result;

    edge_table_board board;
    bit quiet         = 1'b0;   // set for the closing stretch: no idling at all
    bit long_hold_req = 1'b0;   // ask the receiver for one long hold-off
    int n_sent        = 0;      // transfers that the block acts on (unused code excluded)

    sorted_unique_edge_table #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(o_result)
    );

    always #6 i_clk = ~i_clk;

    // Offer one item at the falling edge and hold it until the block takes it.
    // A random idle burst may come first; the item is noted at the edge it transfers.
    task automatic send_item(t_action act, logic signed [EDGE_W-1:0] v);
        t_item it;
        it.action     = act;
        it.edge_value = v;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_item  <= it;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        board.note_item(it);
        if (act != ACT_NONE)
            n_sent++;
        @(negedge i_clk);
    endtask

    // Draw a value: wide random, -8..8, a held entry, an extreme, zero or -1, or -128..127.
    function automatic logic signed [EDGE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1: return EDGE_W'($urandom);
            2: return EDGE_W'($urandom_range(0, 16) - 8);
            3: begin
                if (board.entries.size() != 0)
                    return board.entries[$urandom_range(0, board.entries.size() - 1)];
                return EDGE_W'($urandom_range(0, 16) - 8);
            end
            4: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            default: return EDGE_W'($urandom_range(0, 255) - 128);
        endcase
    endfunction

    // Clear, fill the table to the top with fresh values, then push on it while full:
    // new values must be dropped, held values must still report their index.
    task automatic fill_table();
        int sel;
        send_item(ACT_CLEAR, EDGE_W'($urandom));
        if (!quiet)
            long_hold_req = 1'b1;
        while (board.entries.size() < DEPTH) begin
            if ($urandom_range(0, 9) == 0)
                send_item(ACT_LOOKUP, pick_value());
            else
                send_item(ACT_INSERT, EDGE_W'($urandom));
        end
        repeat (12) begin
            sel = $urandom_range(0, 2);
            if (sel == 0)
                send_item(ACT_INSERT, EDGE_W'($urandom));
            else if (sel == 1)
                send_item(ACT_INSERT, board.entries[$urandom_range(0, DEPTH - 1)]);
            else
                send_item(ACT_LOOKUP, pick_value());
        end
    endtask

    // Mixed traffic over whatever the table holds now.
    task automatic run_mixed(int n);
        int sel;
        repeat (n) begin
            sel = $urandom_range(0, 99);
            if (sel < 48)
                send_item(ACT_INSERT, pick_value());
            else if (sel < 88)
                send_item(ACT_LOOKUP, pick_value());
            else if (sel < 93)
                send_item(ACT_CLEAR, EDGE_W'($urandom));
            else
                send_item(ACT_NONE, EDGE_W'($urandom));
        end
    endtask

    // Receiver: random stalls in bursts, plus one long hold-off on request so the
    // result register stays full and the block must refuse new transfers.
    initial begin : receiver
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold          = LONG_HOLD;
            end else if (hold == 0 && !quiet && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 14);
            end
            if (hold > 0) begin
                i_ready <= 1'b0;
                hold--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Check every result transfer at the edge where it happens.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result(o_result);
    end

    initial begin : stimulus
        board = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty-table miss, both extremes, duplicate insert, neighbors of zero,
        // hits at both ends, unused action code, clear and a miss after it.
        send_item(ACT_LOOKUP, 16'sh0000);
        send_item(ACT_INSERT, 16'sh0000);
        send_item(ACT_INSERT, 16'sh7FFF);
        send_item(ACT_INSERT, 16'sh8000);
        send_item(ACT_INSERT, 16'sh0000);
        send_item(ACT_INSERT, 16'shFFFF);
        send_item(ACT_INSERT, 16'sh0001);
        send_item(ACT_LOOKUP, 16'sh8000);
        send_item(ACT_LOOKUP, 16'sh7FFF);
        send_item(ACT_LOOKUP, 16'sh0002);
        send_item(ACT_NONE,   16'sh5555);
        send_item(ACT_NONE,   16'shAAAA);
        send_item(ACT_INSERT, 16'sh5555);
        send_item(ACT_INSERT, 16'shAAAA);
        send_item(ACT_LOOKUP, 16'shFFFF);
        send_item(ACT_LOOKUP, 16'shAAAA);
        send_item(ACT_CLEAR,  16'shFFFF);
        send_item(ACT_LOOKUP, 16'sh0000);
        send_item(ACT_INSERT, 16'sh0064);
        send_item(ACT_CLEAR,  16'sh0000);

        // Random: one guaranteed fill to full, then mixed traffic with occasional refills.
        // Refill only while a whole one still fits under the target.
        fill_table();
        while (n_sent < ITEM_TARGET) begin
            if (n_sent >= QUIET_AFTER)
                quiet = 1'b1;
            if (n_sent + DEPTH + 40 < ITEM_TARGET && $urandom_range(0, 5) == 0)
                fill_table();
            else
                run_mixed(30);
        end
        i_valid <= 1'b0;

        // Drain: wait for every expected result, then let the pipeline settle.
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Run covered %0d transfers in and %0d results checked; %0d hits, %0d drops",
                 board.n_items, board.n_checked, board.n_hits, board.n_overflow);
        $display("Table peaked at %0d of %0d entries; %0d mismatches",
                 board.peak_fill, DEPTH, board.errors);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Generous fixed limit well beyond the slowest correct run.
    initial begin : watchdog
        #3_000_000;
        $display("timeout: %0d results still expected", board.pending.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ste_pkg.sv
hdl/ste_cell.sv
hdl/sorted_unique_edge_table.sv
bench/sorted_unique_edge_table_test.sv
